### hw/rtl/wrpm_pkg.sv
package wrpm_pkg;

  localparam int ADC_W      = 10;
  localparam int FRAC_BITS  = 10;
  localparam int VSUM_W     = 60;
  localparam int ISUM_W     = 48;
  localparam int CNT_W      = 16;
  localparam int DIV_STEPS  = VSUM_W;
  localparam int SQRT_STEPS = VSUM_W / 2;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int VRMS_W     = 22;
  localparam int IRMS_W     = 16;
  localparam int STEP_W     = 6;

  localparam logic [1:0] SEL_VOLT  = 2'd0;
  localparam logic [1:0] SEL_CUR_A = 2'd1;
  localparam logic [1:0] SEL_CUR_B = 2'd2;
  localparam logic [1:0] SEL_LARGE = 2'd3;

  typedef struct packed {
    logic [9:0]  volt_adc_offset;
    logic [15:0] volt_gain;
    logic [15:0] current_zero;
    logic [9:0]  current_gain;
    logic [15:0] window_length;
    logic [15:0] pulse_numerator;
    logic [15:0] pulse_base;
  } cfg_t;

  typedef struct packed {
    logic       load_in;
    logic       scale;
    logic       square;
    logic       accum;
    logic       clear;
    logic       div_init;
    logic       div_pulse;
    logic       div_step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       root_store;
    logic       period_store;
    logic       out_load;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic pr_zero;
  } sts_t;

endpackage

### hw/rtl/windowed_rms_power_meter.sv
// channel  | handshake               | payload
// in       | in_valid / in_ready     | volt_sample, current_a_sample, current_b_sample
// out      | out_valid / out_ready   | volt_rms, current_a_rms, current_b_rms,
//          |                         | power_level, pulse_period
// apb      | psel, penable, pready   | paddr, pwrite, pwdata, prdata
//
// a sample transfer that does not close the window steps through accept, scale, square and
// accumulate
// a closing transfer adds four passes of a divide and a root in one shared unit, then a
// pulse period divide, which is skipped when the power level is zero
// the result sits in an output register, new samples are taken while it waits; the next
// closing transfer stalls until the held result is taken
// synchronous active-high reset clears sums, count, pulse period and registers to defaults
module windowed_rms_power_meter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wrpm_pkg::ADC_W-1:0]    volt_sample,
  input  logic [wrpm_pkg::ADC_W-1:0]    current_a_sample,
  input  logic [wrpm_pkg::ADC_W-1:0]    current_b_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wrpm_pkg::VRMS_W-1:0]   volt_rms,
  output logic [wrpm_pkg::IRMS_W-1:0]   current_a_rms,
  output logic [wrpm_pkg::IRMS_W-1:0]   current_b_rms,
  output logic [wrpm_pkg::IRMS_W-1:0]   power_level,
  output logic [wrpm_pkg::IRMS_W-1:0]   pulse_period,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import wrpm_pkg::*;

  localparam logic [2:0] REG_VOLT_OFFSET  = 3'd0;
  localparam logic [2:0] REG_VOLT_GAIN    = 3'd1;
  localparam logic [2:0] REG_CUR_ZERO     = 3'd2;
  localparam logic [2:0] REG_CUR_GAIN     = 3'd3;
  localparam logic [2:0] REG_WINDOW       = 3'd4;
  localparam logic [2:0] REG_PULSE_NUM    = 3'd5;
  localparam logic [2:0] REG_PULSE_BASE   = 3'd6;

  cfg_t       cfg;
  cmd_t       cmd;
  sts_t       sts;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.volt_adc_offset <= 10'd128;
      cfg.volt_gain       <= 16'd4420;
      cfg.current_zero    <= 16'd2560;
      cfg.current_gain    <= 10'd30;
      cfg.window_length   <= 16'd20000;
      cfg.pulse_numerator <= 16'd59400;
      cfg.pulse_base      <= 16'd250;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_VOLT_OFFSET: cfg.volt_adc_offset <= pwdata[9:0];
        REG_VOLT_GAIN:   cfg.volt_gain       <= pwdata[15:0];
        REG_CUR_ZERO:    cfg.current_zero    <= pwdata[15:0];
        REG_CUR_GAIN:    cfg.current_gain    <= pwdata[9:0];
        REG_WINDOW:      cfg.window_length   <= pwdata[15:0];
        REG_PULSE_NUM:   cfg.pulse_numerator <= pwdata[15:0];
        REG_PULSE_BASE:  cfg.pulse_base      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_VOLT_OFFSET: prdata = 32'(cfg.volt_adc_offset);
      REG_VOLT_GAIN:   prdata = 32'(cfg.volt_gain);
      REG_CUR_ZERO:    prdata = 32'(cfg.current_zero);
      REG_CUR_GAIN:    prdata = 32'(cfg.current_gain);
      REG_WINDOW:      prdata = 32'(cfg.window_length);
      REG_PULSE_NUM:   prdata = 32'(cfg.pulse_numerator);
      REG_PULSE_BASE:  prdata = 32'(cfg.pulse_base);
      default:         prdata = '0;
    endcase
  end

  wrpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wrpm_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .volt_sample      (volt_sample),
    .current_a_sample (current_a_sample),
    .current_b_sample (current_b_sample),
    .volt_rms         (volt_rms),
    .current_a_rms    (current_a_rms),
    .current_b_rms    (current_b_rms),
    .power_level      (power_level),
    .pulse_period     (pulse_period)
  );

endmodule

### hw/rtl/wrpm_ctrl.sv
module wrpm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  wrpm_pkg::sts_t     sts,
  output wrpm_pkg::cmd_t     cmd
);
  import wrpm_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCALE  = 4'd1;
  localparam logic [3:0] S_SQUARE = 4'd2;
  localparam logic [3:0] S_ACCUM  = 4'd3;
  localparam logic [3:0] S_DINIT  = 4'd4;
  localparam logic [3:0] S_DSTEP  = 4'd5;
  localparam logic [3:0] S_SINIT  = 4'd6;
  localparam logic [3:0] S_SSTEP  = 4'd7;
  localparam logic [3:0] S_RSTORE = 4'd8;
  localparam logic [3:0] S_PCHK   = 4'd9;
  localparam logic [3:0] S_PINIT  = 4'd10;
  localparam logic [3:0] S_PSTEP  = 4'd11;
  localparam logic [3:0] S_PSTORE = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  logic [3:0]        state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic [1:0]        sel, sel_next;
  logic              out_valid_next;
  logic              out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    step_next      = step;
    sel_next       = sel;
    cmd            = '0;
    cmd.sel        = sel;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum  = 1'b1;
        sel_next   = SEL_VOLT;
        state_next = sts.close ? S_DINIT : S_IDLE;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        step_next    = '0;
        state_next   = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = S_SINIT;
        end
      end
      S_SINIT: begin
        cmd.sqrt_init = 1'b1;
        step_next     = '0;
        state_next    = S_SSTEP;
      end
      S_SSTEP: begin
        cmd.sqrt_step = 1'b1;
        step_next     = step + 1'b1;
        if (step == STEP_W'(SQRT_STEPS - 1)) begin
          state_next = S_RSTORE;
        end
      end
      S_RSTORE: begin
        cmd.root_store = 1'b1;
        sel_next       = sel + 1'b1;
        state_next     = (sel == SEL_LARGE) ? S_PCHK : S_DINIT;
      end
      S_PCHK: begin
        cmd.clear  = 1'b1;
        state_next = sts.pr_zero ? S_OUT : S_PINIT;
      end
      S_PINIT: begin
        cmd.div_init  = 1'b1;
        cmd.div_pulse = 1'b1;
        step_next     = '0;
        state_next    = S_PSTEP;
      end
      S_PSTEP: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = S_PSTORE;
        end
      end
      S_PSTORE: begin
        cmd.period_store = 1'b1;
        state_next       = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      sel       <= SEL_VOLT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      sel       <= sel_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### hw/rtl/wrpm_datapath.sv
module wrpm_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  wrpm_pkg::cfg_t                cfg,
  input  wrpm_pkg::cmd_t                cmd,
  output wrpm_pkg::sts_t                sts,
  input  logic [wrpm_pkg::ADC_W-1:0]    volt_sample,
  input  logic [wrpm_pkg::ADC_W-1:0]    current_a_sample,
  input  logic [wrpm_pkg::ADC_W-1:0]    current_b_sample,
  output logic [wrpm_pkg::VRMS_W-1:0]   volt_rms,
  output logic [wrpm_pkg::IRMS_W-1:0]   current_a_rms,
  output logic [wrpm_pkg::IRMS_W-1:0]   current_b_rms,
  output logic [wrpm_pkg::IRMS_W-1:0]   power_level,
  output logic [wrpm_pkg::IRMS_W-1:0]   pulse_period
);
  import wrpm_pkg::*;

  logic [ADC_W-1:0]        vs, as_r, bs;
  logic signed [27:0]      v;
  logic signed [21:0]      a, b;
  logic [53:0]             sv;
  logic [41:0]             sa, sb;
  logic [VSUM_W-1:0]       vsum;
  logic [ISUM_W-1:0]       asum, bsum, lsum;
  logic [CNT_W-1:0]        count;
  logic [15:0]             period;

  logic signed [10:0]      vdiff;
  logic signed [27:0]      v_calc;
  logic [19:0]             a_prod, b_prod;
  logic signed [21:0]      a_calc, b_calc;
  logic [26:0]             vmag;
  logic [20:0]             amag, bmag;
  logic [41:0]             larger;
  logic [VSUM_W:0]         vsum_add;
  logic [ISUM_W:0]         asum_add, bsum_add, lsum_add;
  logic [CNT_W-1:0]        count_inc;

  logic [15:0]             rem, dvs;
  logic [VSUM_W-1:0]       dq;
  logic [16:0]             dtrial;
  logic                    dbit;
  logic [VSUM_W-1:0]       div_src;
  logic [15:0]             n;

  logic [VSUM_W-1:0]       sx;
  logic [31:0]             srem;
  logic [ROOT_W-1:0]       root;
  logic [33:0]             srs, strial;

  logic [VRMS_W-1:0]       vr;
  logic [IRMS_W-1:0]       ar, br, pr;
  logic [IRMS_W-1:0]       root_sat16;
  logic [16:0]             psum;

  assign vdiff  = $signed({1'b0, vs}) - $signed({1'b0, cfg.volt_adc_offset});
  assign v_calc = 28'(vdiff) * $signed({12'd0, cfg.volt_gain});
  assign a_prod = as_r * cfg.current_gain;
  assign b_prod = bs * cfg.current_gain;
  assign a_calc = $signed({6'd0, cfg.current_zero}) - $signed({2'd0, a_prod});
  assign b_calc = $signed({6'd0, cfg.current_zero}) - $signed({2'd0, b_prod});

  assign vmag = v[27] ? 27'(-v) : 27'(v);
  assign amag = a[21] ? 21'(-a) : 21'(a);
  assign bmag = b[21] ? 21'(-b) : 21'(b);

  assign larger   = (sa > sb) ? sa : sb;
  assign vsum_add = {1'b0, vsum} + (VSUM_W + 1)'(sv);
  assign asum_add = {1'b0, asum} + (ISUM_W + 1)'(sa);
  assign bsum_add = {1'b0, bsum} + (ISUM_W + 1)'(sb);
  assign lsum_add = {1'b0, lsum} + (ISUM_W + 1)'(larger);
  assign count_inc = count + 1'b1;

  assign sts.close   = (count_inc >= cfg.window_length);
  assign sts.pr_zero = (pr == '0);

  assign n = (count == '0) ? 16'd1 : count;

  always_comb begin
    case (cmd.sel)
      SEL_VOLT:  div_src = vsum;
      SEL_CUR_A: div_src = VSUM_W'(asum);
      SEL_CUR_B: div_src = VSUM_W'(bsum);
      default:   div_src = VSUM_W'(lsum);
    endcase
  end

  assign dtrial = {rem, dq[VSUM_W-1]};
  assign dbit   = (dtrial >= {1'b0, dvs});

  assign srs    = {srem, sx[VSUM_W-1 -: 2]};
  assign strial = {2'd0, root, 2'b01};

  assign root_sat16 = (|root[ROOT_W-1:IRMS_W]) ? '1 : root[IRMS_W-1:0];
  assign psum = {1'b0, dq[15:0]} + {1'b0, cfg.pulse_base};

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      vs   <= volt_sample;
      as_r <= current_a_sample;
      bs   <= current_b_sample;
    end
    if (cmd.scale) begin
      v <= v_calc;
      a <= a_calc;
      b <= b_calc;
    end
    if (cmd.square) begin
      sv <= vmag * vmag;
      sa <= amag * amag;
      sb <= bmag * bmag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      vsum  <= '0;
      asum  <= '0;
      bsum  <= '0;
      lsum  <= '0;
      count <= '0;
    end else if (cmd.accum) begin
      vsum  <= vsum_add[VSUM_W] ? '1 : vsum_add[VSUM_W-1:0];
      asum  <= asum_add[ISUM_W] ? '1 : asum_add[ISUM_W-1:0];
      bsum  <= bsum_add[ISUM_W] ? '1 : bsum_add[ISUM_W-1:0];
      lsum  <= lsum_add[ISUM_W] ? '1 : lsum_add[ISUM_W-1:0];
      count <= count_inc;
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= '0;
      if (cmd.div_pulse) begin
        dq  <= VSUM_W'(cfg.pulse_numerator) << FRAC_BITS;
        dvs <= pr;
      end else begin
        dq  <= div_src;
        dvs <= n;
      end
    end else if (cmd.div_step) begin
      rem <= dbit ? 16'(dtrial - {1'b0, dvs}) : dtrial[15:0];
      dq  <= {dq[VSUM_W-2:0], dbit};
    end
  end

  // digit-by-digit square root, two radicand bits per cycle
  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sx   <= dq;
      srem <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      sx <= {sx[VSUM_W-3:0], 2'b00};
      if (srs >= strial) begin
        srem <= 32'(srs - strial);
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        srem <= srs[31:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_store) begin
      case (cmd.sel)
        SEL_VOLT:  vr <= (|root[ROOT_W-1:VRMS_W]) ? '1 : root[VRMS_W-1:0];
        SEL_CUR_A: ar <= root_sat16;
        SEL_CUR_B: br <= root_sat16;
        default:   pr <= root_sat16;
      endcase
    end
    if (cmd.out_load) begin
      volt_rms      <= vr;
      current_a_rms <= ar;
      current_b_rms <= br;
      power_level   <= pr;
      pulse_period  <= period;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= '0;
    end else if (cmd.period_store) begin
      period <= ((|dq[VSUM_W-1:16]) || psum[16]) ? '1 : psum[15:0];
    end
  end

endmodule
